FILE: src/tgec_pkg.sv
// shared types, register codes and coordinate helpers for the touch gesture classifier
`timescale 1ns / 1ps

package tgec_pkg;

	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;
	localparam int DIM_W      = 13;
	localparam int COORD_W    = 12;
	localparam int WRAP_W     = 16;
	localparam int TIME_W     = 32;
	localparam int LP_W       = 16;

	localparam logic [DIM_W-1:0] DIM_MAX = 13'd4096;

	typedef enum logic [2:0] {
		EV_PRESSED       = 3'd0,
		EV_MOVED         = 3'd1,
		EV_LONG_PRESSED  = 3'd2,
		EV_RELEASED      = 3'd3,
		EV_LONG_RELEASED = 3'd4
	} event_kind_t;

	typedef enum logic [2:0] {
		REG_PANEL_WIDTH   = 3'd0,
		REG_PANEL_HEIGHT  = 3'd1,
		REG_ROTATION_MODE = 3'd2,
		REG_MIRROR_H      = 3'd3,
		REG_MIRROR_V      = 3'd4,
		REG_LONG_PRESS_MS = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [DIM_W-1:0] panel_width;
		logic [DIM_W-1:0] panel_height;
		logic [1:0]       rotation_mode;
		logic             mirror_horizontal;
		logic             mirror_vertical;
		logic [LP_W-1:0]  long_press_ms;
	} cfg_t;

	// zero acts as one, anything past 4096 acts as 4096
	function automatic logic [WRAP_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
		logic [WRAP_W-1:0] r;
		if (d == '0)
			r = WRAP_W'(1);
		else if (d > DIM_MAX)
			r = WRAP_W'(DIM_MAX);
		else
			r = WRAP_W'(d);
		return r;
	endfunction

	// dim - 1 - v, wrapping at 16 bits
	function automatic logic [WRAP_W-1:0] flip16(input logic [WRAP_W-1:0] dim,
		input logic [WRAP_W-1:0] v);
		return dim - WRAP_W'(1) - v;
	endfunction

endpackage

FILE: src/tgec_if.sv
// request channel interfaces for touch polls and gesture events
`timescale 1ns / 1ps

interface tgec_poll_if;
	logic                          valid;
	logic                          ready;
	logic                          read_ok;
	logic [3:0]                    point_count;
	logic [tgec_pkg::COORD_W-1:0]  raw_x;
	logic [tgec_pkg::COORD_W-1:0]  raw_y;
	logic [tgec_pkg::TIME_W-1:0]   now_ms;

	modport source (output valid, read_ok, point_count, raw_x, raw_y, now_ms, input ready);
	modport sink (input valid, read_ok, point_count, raw_x, raw_y, now_ms, output ready);
endinterface

interface tgec_event_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    event_kind;
	logic [tgec_pkg::COORD_W-1:0]  event_x;
	logic [tgec_pkg::COORD_W-1:0]  event_y;

	modport source (output valid, event_kind, event_x, event_y, input ready);
	modport sink (input valid, event_kind, event_x, event_y, output ready);
endinterface

FILE: src/tgec_xform.sv
// rotation, mirroring and clamping of a raw touch point to panel coordinates
`timescale 1ns / 1ps

module tgec_xform (
	input  tgec_pkg::cfg_t                cfg,
	input  logic [tgec_pkg::COORD_W-1:0]  raw_x,
	input  logic [tgec_pkg::COORD_W-1:0]  raw_y,
	output logic [tgec_pkg::COORD_W-1:0]  x,
	output logic [tgec_pkg::COORD_W-1:0]  y
);

	logic [tgec_pkg::WRAP_W-1:0] w;
	logic [tgec_pkg::WRAP_W-1:0] h;
	logic [tgec_pkg::WRAP_W-1:0] px0, py0;
	logic [tgec_pkg::WRAP_W-1:0] rx, ry;
	logic [tgec_pkg::WRAP_W-1:0] mx, my;
	logic [tgec_pkg::WRAP_W-1:0] cx, cy;

	assign w   = tgec_pkg::eff_dim(cfg.panel_width);
	assign h   = tgec_pkg::eff_dim(cfg.panel_height);
	assign px0 = tgec_pkg::WRAP_W'(raw_x);
	assign py0 = tgec_pkg::WRAP_W'(raw_y);

	// quarter turn one uses the width for y
	always_comb begin
		unique case (cfg.rotation_mode)
			2'd1: begin
				rx = py0;
				ry = tgec_pkg::flip16(w, px0);
			end
			2'd2: begin
				rx = tgec_pkg::flip16(w, px0);
				ry = tgec_pkg::flip16(h, py0);
			end
			2'd3: begin
				rx = tgec_pkg::flip16(h, py0);
				ry = px0;
			end
			default: begin
				rx = px0;
				ry = py0;
			end
		endcase
	end

	assign mx = cfg.mirror_horizontal ? tgec_pkg::flip16(w, rx) : rx;
	assign my = cfg.mirror_vertical ? tgec_pkg::flip16(h, ry) : ry;

	assign cx = (mx < w) ? mx : (w - tgec_pkg::WRAP_W'(1));
	assign cy = (my < h) ? my : (h - tgec_pkg::WRAP_W'(1));

	assign x = cx[tgec_pkg::COORD_W-1:0];
	assign y = cy[tgec_pkg::COORD_W-1:0];

endmodule

FILE: src/tgec_gesture.sv
// press state tracking and the registered gesture event output
`timescale 1ns / 1ps

module tgec_gesture (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s1,
	input  logic                          touched_s1,
	input  logic [tgec_pkg::COORD_W-1:0]  x,
	input  logic [tgec_pkg::COORD_W-1:0]  y,
	input  logic [tgec_pkg::TIME_W-1:0]   now_s1,
	input  logic [tgec_pkg::LP_W-1:0]     long_press_ms,
	output logic                          take,
	tgec_event_if.source                  evt
);

	logic                          pressed_q;
	logic                          long_q;
	logic [tgec_pkg::COORD_W-1:0]  last_x_q;
	logic [tgec_pkg::COORD_W-1:0]  last_y_q;
	logic [tgec_pkg::TIME_W-1:0]   start_q;

	logic                          ev_valid_q;
	tgec_pkg::event_kind_t         ev_kind_q;
	logic [tgec_pkg::COORD_W-1:0]  ev_x_q;
	logic [tgec_pkg::COORD_W-1:0]  ev_y_q;

	logic                          out_free;
	logic                          emit;
	tgec_pkg::event_kind_t         kind;
	logic [tgec_pkg::COORD_W-1:0]  ex, ey;
	logic [tgec_pkg::TIME_W-1:0]   elapsed;
	logic                          moved;

	assign out_free = !ev_valid_q || evt.ready;
	assign take     = valid_s1 && out_free;
	assign elapsed  = now_s1 - start_q;
	assign moved    = (x != last_x_q) || (y != last_y_q);

	always_comb begin
		emit = 1'b0;
		kind = tgec_pkg::EV_PRESSED;
		ex   = x;
		ey   = y;
		priority if (touched_s1 && !pressed_q) begin
			emit = 1'b1;
		end else if (touched_s1) begin
			if (moved) begin
				emit = 1'b1;
				kind = tgec_pkg::EV_MOVED;
			end else if (!long_q && elapsed >= tgec_pkg::TIME_W'(long_press_ms)) begin
				emit = 1'b1;
				kind = tgec_pkg::EV_LONG_PRESSED;
			end
		end else if (pressed_q) begin
			emit = 1'b1;
			kind = long_q ? tgec_pkg::EV_LONG_RELEASED : tgec_pkg::EV_RELEASED;
			ex   = last_x_q;
			ey   = last_y_q;
		end else begin
			emit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q <= 1'b0;
			long_q    <= 1'b0;
			last_x_q  <= '0;
			last_y_q  <= '0;
			start_q   <= '0;
		end else if (take) begin
			if (touched_s1 && !pressed_q) begin
				pressed_q <= 1'b1;
				long_q    <= 1'b0;
				last_x_q  <= x;
				last_y_q  <= y;
				start_q   <= now_s1;
			end else if (touched_s1) begin
				if (moved) begin
					last_x_q <= x;
					last_y_q <= y;
				end else if (emit) begin
					long_q <= 1'b1;
				end
			end else begin
				pressed_q <= 1'b0;
				long_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_q <= 1'b0;
		end else if (out_free) begin
			ev_valid_q <= take && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			ev_kind_q <= kind;
			ev_x_q    <= ex;
			ev_y_q    <= ey;
		end
	end

	assign evt.valid      = ev_valid_q;
	assign evt.event_kind = ev_kind_q;
	assign evt.event_x    = ev_x_q;
	assign evt.event_y    = ev_y_q;

	a_long_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		long_q |-> pressed_q)
		else $error("long press flag set without a press");

	a_emit_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		take && emit |=> ev_valid_q)
		else $error("event lost on its way to the output register");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid_q && (ev_kind_q == tgec_pkg::EV_RELEASED ||
		ev_kind_q == tgec_pkg::EV_LONG_RELEASED) |-> !pressed_q)
		else $error("release reported while still pressed");

	a_press_sets: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid_q && ev_kind_q == tgec_pkg::EV_PRESSED |-> pressed_q && !long_q)
		else $error("press reported without entering the pressed state");

endmodule

FILE: src/touch_gesture_event_classifier_core.sv
// Touch gesture classifier: takes one touch-panel poll per clock and reports pressed, moved,
// long pressed, released or long released. A poll is registered in the poll register on
// acceptance, then rotated, mirrored, clamped and classified into a result register once the
// output is free, so polls may follow each other in every cycle while the output is free. A
// stalled event holds the poll register, and with it the input, until the event is taken;
// with the output free, polls pass through at one per cycle. Panel geometry, rotation,
// mirroring and the long-press time sit in APB registers at byte addresses 0, 4, 8, 12, 16
// and 20; the user writes them only while idle, which the block itself does not enforce.
`timescale 1ns / 1ps

module touch_gesture_event_classifier_core (
	input  logic                              clk,
	input  logic                              arst_n,
	tgec_poll_if.sink                         poll,
	tgec_event_if.source                      evt,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tgec_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [tgec_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [tgec_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready
);

	tgec_pkg::cfg_t                cfg_q;
	logic [2:0]                    reg_sel;
	logic                          wr_en;

	logic                          valid_s1;
	logic                          touched_s1;
	logic [tgec_pkg::COORD_W-1:0]  raw_x_s1;
	logic [tgec_pkg::COORD_W-1:0]  raw_y_s1;
	logic [tgec_pkg::TIME_W-1:0]   now_s1;

	logic [tgec_pkg::COORD_W-1:0]  x;
	logic [tgec_pkg::COORD_W-1:0]  y;
	logic                          take;

	assign pready  = 1'b1;
	assign reg_sel = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.panel_width       <= tgec_pkg::DIM_W'(240);
			cfg_q.panel_height      <= tgec_pkg::DIM_W'(240);
			cfg_q.rotation_mode     <= 2'd0;
			cfg_q.mirror_horizontal <= 1'b0;
			cfg_q.mirror_vertical   <= 1'b0;
			cfg_q.long_press_ms     <= tgec_pkg::LP_W'(2000);
		end else if (wr_en) begin
			unique case (reg_sel)
				tgec_pkg::REG_PANEL_WIDTH:   cfg_q.panel_width <= pwdata[12:0];
				tgec_pkg::REG_PANEL_HEIGHT:  cfg_q.panel_height <= pwdata[12:0];
				tgec_pkg::REG_ROTATION_MODE: cfg_q.rotation_mode <= pwdata[1:0];
				tgec_pkg::REG_MIRROR_H:      cfg_q.mirror_horizontal <= pwdata[0];
				tgec_pkg::REG_MIRROR_V:      cfg_q.mirror_vertical <= pwdata[0];
				tgec_pkg::REG_LONG_PRESS_MS: cfg_q.long_press_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			tgec_pkg::REG_PANEL_WIDTH:   prdata = tgec_pkg::CFG_DATA_W'(cfg_q.panel_width);
			tgec_pkg::REG_PANEL_HEIGHT:  prdata = tgec_pkg::CFG_DATA_W'(cfg_q.panel_height);
			tgec_pkg::REG_ROTATION_MODE: prdata = tgec_pkg::CFG_DATA_W'(cfg_q.rotation_mode);
			tgec_pkg::REG_MIRROR_H:      prdata = tgec_pkg::CFG_DATA_W'(cfg_q.mirror_horizontal);
			tgec_pkg::REG_MIRROR_V:      prdata = tgec_pkg::CFG_DATA_W'(cfg_q.mirror_vertical);
			tgec_pkg::REG_LONG_PRESS_MS: prdata = tgec_pkg::CFG_DATA_W'(cfg_q.long_press_ms);
			default:                     prdata = '0;
		endcase
	end

	// poll register frees up whenever its content is consumed
	assign poll.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			touched_s1 <= poll.read_ok && (poll.point_count != 4'd0);
			raw_x_s1   <= poll.raw_x;
			raw_y_s1   <= poll.raw_y;
			now_s1     <= poll.now_ms;
		end
	end

	tgec_xform u_xform (
		.cfg   (cfg_q),
		.raw_x (raw_x_s1),
		.raw_y (raw_y_s1),
		.x     (x),
		.y     (y)
	);

	tgec_gesture u_gesture (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.touched_s1    (touched_s1),
		.x             (x),
		.y             (y),
		.now_s1        (now_s1),
		.long_press_ms (cfg_q.long_press_ms),
		.take          (take),
		.evt           (evt)
	);

endmodule
